[rtl/multichannel_message_queue_unit_assert.svh]
// Assertion macros for the multichannel message queue unit.
// Each macro expects clk and arst_n in the scope where it is used.
`ifndef MULTICHANNEL_MESSAGE_QUEUE_UNIT_ASSERT_SVH
`define MULTICHANNEL_MESSAGE_QUEUE_UNIT_ASSERT_SVH

// same-cycle implication
`define MMQ_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("mmq assertion failed");

// next-cycle implication
`define MMQ_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("mmq assertion failed");

`endif

[rtl/mmq_pkg.sv]
// Shared types and constants of the multichannel message queue unit.
// No dependencies.
package mmq_pkg;

	localparam int CHAN_FIELD_W = 3;
	localparam int LIMIT_W      = 5;
	localparam int DATA_W       = 32;

	typedef enum logic [1:0] {
		KIND_OPEN  = 2'd0,
		KIND_CLOSE = 2'd1,
		KIND_SEND  = 2'd2,
		KIND_RECV  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_NO_CHANNEL  = 2'd1,
		ST_WOULD_BLOCK = 2'd2,
		ST_NO_FREE     = 2'd3
	} status_t;

	typedef struct packed {
		kind_t                    kind;
		logic [CHAN_FIELD_W-1:0]  channel;
		logic [LIMIT_W-1:0]       limit;
		logic [DATA_W-1:0]        in_data;
	} req_t;

	typedef struct packed {
		status_t                  status;
		logic [CHAN_FIELD_W-1:0]  opened_channel;
		logic [DATA_W-1:0]        out_data;
	} resp_t;

	// outcome of one request, channel table to datapath
	typedef struct packed {
		status_t                  status;
		logic [CHAN_FIELD_W-1:0]  opened;
		logic                     wr_en;
		logic                     rd_en;
	} dec_t;

endpackage

[rtl/mmq_stream_if.sv]
// Valid/ready stream interface carrying one payload per beat.
// Payload type is set per instance; no other dependencies.
interface mmq_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink   (input valid, input payload, output ready);
endinterface

[rtl/mmq_msg_store.sv]
// Shared message store: one write or one read per cycle, registered read data.
// Depends on nothing but its parameters.
module mmq_msg_store #(
	parameter int DEPTH     = 128,
	parameter int ADDR_W    = 7,
	parameter int WORD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 wr_en,
	input  logic                 rd_en,
	input  logic [ADDR_W-1:0]    addr,
	input  logic [WORD_BITS-1:0] wr_data,
	output logic [WORD_BITS-1:0] rd_data
);

	logic [WORD_BITS-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[addr];
		end
	end

endmodule

[rtl/mmq_chan_tbl.sv]
// Per-channel state (open, limit, count, head) and request decode.
// Depends on mmq_pkg and multichannel_message_queue_unit_assert.svh.
`include "multichannel_message_queue_unit_assert.svh"

module mmq_chan_tbl import mmq_pkg::*; #(
	parameter int NUM_CHANNELS = 8,
	parameter int FIFO_DEPTH   = 16,
	parameter int ADDR_W       = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              fire,
	input  req_t              req,
	output dec_t              dec,
	output logic [ADDR_W-1:0] addr
);

	localparam int CH_W  = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
	localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
	localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int SUM_W = CNT_W + 1;

	logic [NUM_CHANNELS-1:0] open_q;
	logic [CNT_W-1:0]        lim_q  [NUM_CHANNELS];
	logic [CNT_W-1:0]        cnt_q  [NUM_CHANNELS];
	logic [PTR_W-1:0]        head_q [NUM_CHANNELS];

	logic             ch_ok;
	logic [CH_W-1:0]  ch_idx;
	logic             ch_live;
	logic [CNT_W-1:0] cur_cnt;
	logic [CNT_W-1:0] cur_lim;
	logic [PTR_W-1:0] cur_head;
	logic             any_free;
	logic [CH_W-1:0]  free_idx;
	logic [CNT_W-1:0] lim_sat;
	logic [SUM_W-1:0] sum;
	logic [PTR_W-1:0] slot;
	logic [PTR_W:0]   head_inc;
	logic [PTR_W-1:0] head_nxt;

	always_comb begin
		ch_ok    = int'(req.channel) < NUM_CHANNELS;
		ch_idx   = CH_W'(req.channel);
		ch_live  = ch_ok ? open_q[ch_idx] : 1'b0;
		cur_cnt  = ch_ok ? cnt_q[ch_idx]  : '0;
		cur_lim  = ch_ok ? lim_q[ch_idx]  : '0;
		cur_head = ch_ok ? head_q[ch_idx] : '0;
	end

	// lowest closed channel
	always_comb begin
		any_free = 1'b0;
		free_idx = '0;
		for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
			if (!open_q[i]) begin
				any_free = 1'b1;
				free_idx = CH_W'(i);
			end
		end
	end

	always_comb begin
		lim_sat  = (int'(req.limit) > FIFO_DEPTH) ? CNT_W'(FIFO_DEPTH) : CNT_W'(req.limit);
		sum      = SUM_W'(cur_head) + SUM_W'(cur_cnt);
		slot     = (int'(sum) >= FIFO_DEPTH) ? PTR_W'(sum - SUM_W'(FIFO_DEPTH)) : PTR_W'(sum);
		head_inc = (PTR_W + 1)'(cur_head) + (PTR_W + 1)'(1);
		head_nxt = (int'(head_inc) == FIFO_DEPTH) ? '0 : PTR_W'(head_inc);
	end

	always_comb begin
		dec = '{status: ST_OK, opened: '0, wr_en: 1'b0, rd_en: 1'b0};
		unique case (req.kind)
			KIND_OPEN: begin
				if (any_free) begin
					dec.opened = CHAN_FIELD_W'(free_idx);
				end else begin
					dec.status = ST_NO_FREE;
				end
			end
			KIND_CLOSE: begin
				dec.status = ST_OK;
			end
			KIND_SEND: begin
				if (!ch_live) begin
					dec.status = ST_NO_CHANNEL;
				end else if (cur_cnt >= cur_lim) begin
					dec.status = ST_WOULD_BLOCK;
				end else begin
					dec.wr_en = fire;
				end
			end
			KIND_RECV: begin
				if (!ch_live) begin
					dec.status = ST_NO_CHANNEL;
				end else if (cur_cnt == '0) begin
					dec.status = ST_WOULD_BLOCK;
				end else begin
					dec.rd_en = fire;
				end
			end
			default: begin
				dec.status = ST_OK;
			end
		endcase
	end

	assign addr = ADDR_W'(ch_idx) * ADDR_W'(FIFO_DEPTH)
		+ ADDR_W'((req.kind == KIND_SEND) ? slot : cur_head);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= '0;
			for (int i = 0; i < NUM_CHANNELS; i++) begin
				lim_q[i]  <= '0;
				cnt_q[i]  <= '0;
				head_q[i] <= '0;
			end
		end else if (fire) begin
			case (req.kind)
				KIND_OPEN: begin
					if (any_free) begin
						open_q[free_idx] <= 1'b1;
						lim_q[free_idx]  <= lim_sat;
						cnt_q[free_idx]  <= '0;
						head_q[free_idx] <= '0;
					end
				end
				KIND_CLOSE: begin
					if (ch_live) begin
						open_q[ch_idx] <= 1'b0;
						lim_q[ch_idx]  <= '0;
						cnt_q[ch_idx]  <= '0;
						head_q[ch_idx] <= '0;
					end
				end
				KIND_SEND: begin
					if (dec.wr_en) begin
						cnt_q[ch_idx] <= cur_cnt + CNT_W'(1);
					end
				end
				KIND_RECV: begin
					if (dec.rd_en) begin
						cnt_q[ch_idx]  <= cur_cnt - CNT_W'(1);
						head_q[ch_idx] <= head_nxt;
					end
				end
				default: begin
				end
			endcase
		end
	end

	`MMQ_ASSERT_IMP(a_cnt_within_lim, fire && ch_ok, cur_cnt <= cur_lim)
	`MMQ_ASSERT_IMP(a_mem_only_on_fire, dec.wr_en || dec.rd_en, fire && !(dec.wr_en && dec.rd_en))
	`MMQ_ASSERT_NXT(a_open_claims, fire && req.kind == KIND_OPEN && any_free,
		open_q[$past(free_idx)])

endmodule

[rtl/multichannel_message_queue_unit.sv]
// Multichannel message queue unit: channel table, message store, output register.
// Depends on mmq_pkg, mmq_stream_if, mmq_chan_tbl and mmq_msg_store.
//
// Usage:
//   req  (sink):   one request per beat: open, close, try send or try receive.
//   resp (source): exactly one result per request, in request order.
// A request is registered on acceptance, decoded against the channel table
// while it waits in that register, and its result lands in the output register
// together with the message store read data. resp.valid rises when the result
// enters the output register; throughput is one request per cycle while resp.ready
// is high, set by the single port of the message store and the channel table update.
// Reset clears every channel to closed with zero limit, count and head; the
// message store is not cleared and needs no pass after reset.
// When resp.ready is low the result holds, the registered request waits and
// req.ready drops only once both stages are full; no beat is lost or repeated.
module multichannel_message_queue_unit import mmq_pkg::*; #(
	parameter int NUM_CHANNELS = 8,
	parameter int FIFO_DEPTH   = 16,
	parameter int WORD_BITS    = 32
) (
	input  logic         clk,
	input  logic         arst_n,
	mmq_stream_if.sink   req,
	mmq_stream_if.source resp
);

	localparam int TOTAL  = NUM_CHANNELS * FIFO_DEPTH;
	localparam int ADDR_W = (TOTAL > 1) ? $clog2(TOTAL) : 1;

	logic                 valid_s1;
	req_t                 req_s1;
	logic                 fire;
	dec_t                 dec;
	logic [ADDR_W-1:0]    addr;
	logic [WORD_BITS-1:0] rd_data;

	logic                    out_valid_q;
	status_t                 status_q;
	logic [CHAN_FIELD_W-1:0] opened_q;
	logic                    rdv_q;

	assign fire      = valid_s1 && (!out_valid_q || resp.ready);
	assign req.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			req_s1 <= req.payload;
		end
	end

	mmq_chan_tbl #(
		.NUM_CHANNELS (NUM_CHANNELS),
		.FIFO_DEPTH   (FIFO_DEPTH),
		.ADDR_W       (ADDR_W)
	) u_chan_tbl (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.req    (req_s1),
		.dec    (dec),
		.addr   (addr)
	);

	mmq_msg_store #(
		.DEPTH     (TOTAL),
		.ADDR_W    (ADDR_W),
		.WORD_BITS (WORD_BITS)
	) u_msg_store (
		.clk     (clk),
		.wr_en   (dec.wr_en),
		.rd_en   (dec.rd_en),
		.addr    (addr),
		.wr_data (WORD_BITS'(req_s1.in_data)),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			rdv_q       <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
			rdv_q       <= dec.rd_en;
		end else if (resp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q <= dec.status;
			opened_q <= dec.opened;
		end
	end

	assign resp.valid                  = out_valid_q;
	assign resp.payload.status         = status_q;
	assign resp.payload.opened_channel = opened_q;
	assign resp.payload.out_data       = rdv_q ? DATA_W'(rd_data) : '0;

endmodule

[verif/testbench.sv]
// Self-checking testbench for multichannel_message_queue_unit: open, close, try send
// and try receive requests against a predictor of the channel table and message store.
// Depends on mmq_pkg, mmq_stream_if and multichannel_message_queue_unit from the RTL.
module testbench import mmq_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NUM_CH      = 8;
	localparam int DEPTH       = 16;
	localparam int CYCLE_LIMIT = 300000;
	localparam int RANDOM_ITEMS = 1300;

	class queue_scoreboard;
		bit          chan_open  [NUM_CH];
		logic [4:0]  chan_limit [NUM_CH];
		logic [4:0]  chan_count [NUM_CH];
		logic [3:0]  chan_head  [NUM_CH];
		logic [31:0] words      [NUM_CH*DEPTH];
		resp_t       expected_results[$];
		int          failures;

		function new();
			for (int c = 0; c < NUM_CH; c++) begin
				chan_open[c]  = 1'b0;
				chan_limit[c] = '0;
				chan_count[c] = '0;
				chan_head[c]  = '0;
			end
			failures = 0;
		endfunction

		function resp_t apply_request(req_t r);
			resp_t o;
			int    ch;
			int    slot;
			ch = int'(r.channel);
			o.status         = ST_OK;
			o.opened_channel = '0;
			o.out_data       = '0;
			case (r.kind)
				KIND_OPEN: begin
					o.status = ST_NO_FREE;
					for (int c = 0; c < NUM_CH; c++) begin
						if (!chan_open[c]) begin
							chan_open[c]  = 1'b1;
							chan_limit[c] = (int'(r.limit) > DEPTH) ? 5'(DEPTH) : r.limit;
							chan_count[c] = '0;
							chan_head[c]  = '0;
							o.status         = ST_OK;
							o.opened_channel = 3'(c);
							break;
						end
					end
				end
				KIND_CLOSE: begin
					if (chan_open[ch]) begin
						chan_open[ch]  = 1'b0;
						chan_limit[ch] = '0;
						chan_count[ch] = '0;
						chan_head[ch]  = '0;
					end
				end
				KIND_SEND: begin
					if (!chan_open[ch]) begin
						o.status = ST_NO_CHANNEL;
					end else if (chan_count[ch] >= chan_limit[ch]) begin
						o.status = ST_WOULD_BLOCK;
					end else begin
						slot = (int'(chan_head[ch]) + int'(chan_count[ch])) % DEPTH;
						words[ch*DEPTH + slot] = r.in_data;
						chan_count[ch] = chan_count[ch] + 5'd1;
					end
				end
				default: begin
					if (!chan_open[ch]) begin
						o.status = ST_NO_CHANNEL;
					end else if (chan_count[ch] == 0) begin
						o.status = ST_WOULD_BLOCK;
					end else begin
						slot = int'(chan_head[ch]);
						o.out_data = words[ch*DEPTH + slot];
						chan_head[ch]  = 4'((slot + 1) % DEPTH);
						chan_count[ch] = chan_count[ch] - 5'd1;
					end
				end
			endcase
			return o;
		endfunction

		function void note_request(req_t r);
			expected_results.push_back(apply_request(r));
		endfunction

		function void check_result(resp_t got);
			resp_t want;
			if (expected_results.size() == 0) begin
				$error("result beat with nothing expected: status %0d", got.status);
				failures++;
				return;
			end
			want = expected_results.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				failures++;
			end
			if (got.opened_channel !== want.opened_channel) begin
				$error("opened_channel: expected %0d, got %0d",
					want.opened_channel, got.opened_channel);
				failures++;
			end
			if (got.out_data !== want.out_data) begin
				$error("out_data: expected %08h, got %08h", want.out_data, got.out_data);
				failures++;
			end
		endfunction

		function int pending();
			return expected_results.size();
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycles = 0;

	mmq_stream_if #(.payload_t(req_t))  req_if ();
	mmq_stream_if #(.payload_t(resp_t)) resp_if ();

	queue_scoreboard sb = new();

	multichannel_message_queue_unit #(
		.NUM_CHANNELS (NUM_CH),
		.FIFO_DEPTH   (DEPTH),
		.WORD_BITS    (32)
	) u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.resp   (resp_if)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL multichannel_message_queue_unit");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && resp_if.valid && resp_if.ready)
			sb.check_result(resp_if.payload);
	end

	// receiver stall pattern: free-running, random, periodic or blocked stretches
	initial begin
		int mode;
		int stretch;
		int tick;
		resp_if.ready = 1'b0;
		mode = 0;
		stretch = 0;
		tick = 0;
		forever begin
			@(negedge clk);
			if (stretch == 0) begin
				mode = $urandom_range(0, 3);
				stretch = (mode == 3) ? $urandom_range(1, 12) : $urandom_range(20, 200);
			end
			stretch--;
			tick++;
			case (mode)
				0:       resp_if.ready = 1'b1;
				1:       resp_if.ready = ($urandom_range(0, 99) >= 35);
				2:       resp_if.ready = (tick % 3 != 0);
				default: resp_if.ready = 1'b0;
			endcase
		end
	end

	task automatic push_request(req_t r);
		@(negedge clk);
		req_if.valid   = 1'b1;
		req_if.payload = r;
		do @(posedge clk); while (!req_if.ready);
		sb.note_request(r);
	endtask

	task automatic hold_off(int n);
		@(negedge clk);
		req_if.valid = 1'b0;
		repeat (n - 1) @(negedge clk);
	endtask

	task automatic wait_for_drain();
		hold_off(1);
		while (sb.pending() != 0) @(posedge clk);
	endtask

	function automatic req_t make_req(kind_t k, int ch, int lim, logic [31:0] data);
		req_t r;
		r.kind    = k;
		r.channel = 3'(ch);
		r.limit   = 5'(lim);
		r.in_data = data;
		return r;
	endfunction

	// mostly requests aimed at open channels; send_pct sets fill versus drain
	function automatic req_t random_request(int send_pct);
		req_t r;
		int   roll;
		int   live[$];
		for (int c = 0; c < NUM_CH; c++)
			if (sb.chan_open[c]) live.push_back(c);
		r.in_data = $urandom;
		r.limit   = ($urandom_range(0, 99) < 70) ? 5'($urandom_range(1, DEPTH))
			: 5'($urandom_range(0, 31));
		if (live.size() != 0 && $urandom_range(0, 99) < 85)
			r.channel = 3'(live[$urandom_range(0, live.size() - 1)]);
		else
			r.channel = 3'($urandom_range(0, NUM_CH - 1));
		roll = $urandom_range(0, 99);
		if (roll < 7)
			r.kind = KIND_OPEN;
		else if (roll < 12)
			r.kind = KIND_CLOSE;
		else if ($urandom_range(0, 99) < send_pct)
			r.kind = KIND_SEND;
		else
			r.kind = KIND_RECV;
		return r;
	endfunction

	initial begin
		int burst;
		int send_pct;
		arst_n         = 1'b0;
		req_if.valid   = 1'b0;
		req_if.payload = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: closed channels, zero and saturated limits, full, empty, no free
		push_request(make_req(KIND_RECV,  0, 0, 32'h0));
		push_request(make_req(KIND_SEND,  7, 0, 32'hA5A5_5A5A));
		push_request(make_req(KIND_CLOSE, 3, 0, 32'h0));
		push_request(make_req(KIND_OPEN,  5, 0, 32'h0));
		push_request(make_req(KIND_SEND,  0, 0, 32'h1234_5678));
		push_request(make_req(KIND_OPEN,  0, 31, 32'h0));
		push_request(make_req(KIND_RECV,  1, 0, 32'h0));
		push_request(make_req(KIND_OPEN,  0, 1, 32'h0));
		push_request(make_req(KIND_SEND,  2, 0, 32'hFFFF_FFFF));
		push_request(make_req(KIND_SEND,  2, 0, 32'hDEAD_BEEF));
		push_request(make_req(KIND_RECV,  2, 0, 32'h0));
		push_request(make_req(KIND_RECV,  2, 0, 32'h0));
		push_request(make_req(KIND_OPEN,  7, 16, 32'h0));
		push_request(make_req(KIND_SEND,  3, 0, 32'h0000_0000));
		for (int i = 0; i < 4; i++)
			push_request(make_req(KIND_OPEN, 0, 17 + i, 32'h0));
		push_request(make_req(KIND_OPEN,  0, 8, 32'h0));
		push_request(make_req(KIND_CLOSE, 0, 0, 32'h0));
		push_request(make_req(KIND_OPEN,  6, 2, 32'h0));
		push_request(make_req(KIND_CLOSE, 3, 0, 32'h0));
		push_request(make_req(KIND_RECV,  3, 0, 32'h0));
		wait_for_drain();

		burst = 0;
		send_pct = 50;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 100 == 0)
				send_pct = (n % 300 == 0) ? 80 : ((n % 300 == 100) ? 20 : 50);
			if (n % 400 == 399)
				wait_for_drain();
			if (burst == 0) begin
				burst = $urandom_range(1, 40);
				if ($urandom_range(0, 3) != 0)
					hold_off($urandom_range(1, 6));
			end
			burst--;
			push_request(random_request(send_pct));
		end
		hold_off(1);

		while (sb.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.failures == 0)
			$display("PASS multichannel_message_queue_unit");
		else
			$display("FAIL multichannel_message_queue_unit");
		$finish;
	end
endmodule

[multichannel_message_queue_unit.f]
+incdir+rtl
rtl/mmq_pkg.sv
rtl/mmq_stream_if.sv
rtl/mmq_msg_store.sv
rtl/mmq_chan_tbl.sv
rtl/multichannel_message_queue_unit.sv
verif/testbench.sv
